[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ppsst_pkg.sv]
package ppsst_pkg;

    localparam int INTERFACES_DEF = 4;
    localparam int SERVERS_DEF = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TEST   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [3:0]  port_index;
        logic [31:0] address;
        logic [3:0]  position;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_address;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

endpackage

[design/per_port_server_set_table.sv]
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid, req_stall | ppsst_pkg::req_t
// rsp     | out       | rsp_valid, rsp_stall | ppsst_pkg::rsp_t
//
// One request word is taken at a time, and every entry visit costs a memory read.
// An invalid port is answered with a zero word, and a read past the count with ok low.
// Add, test and remove scan the entries in order, reading and comparing each, up to a match
// or the end; remove then shifts each later entry down by a read and a write. A finished
// result waits while rsp_stall holds the previous one. Reset clears the per-port counts at
// once; the address store is not cleared.
module per_port_server_set_table #(
    parameter int INTERFACES = ppsst_pkg::INTERFACES_DEF,
    parameter int SERVERS = ppsst_pkg::SERVERS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ppsst_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ppsst_pkg::rsp_t rsp
);

    localparam int DEPTH = INTERFACES * SERVERS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;
    localparam int CW = $clog2(SERVERS + 1);
    localparam logic [CW-1:0] FULL = CW'(SERVERS);

    ppsst_pkg::state_t state_reg, state_next;
    ppsst_pkg::op_t    op_reg, op_next;
    logic [PW-1:0]     port_reg, port_next;
    logic [31:0]       addr_reg, addr_next;
    logic [3:0]        pos_reg, pos_next;
    logic [CW-1:0]     idx_reg, idx_next;
    ppsst_pkg::rsp_t   res_reg, res_next;
    ppsst_pkg::rsp_t   rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]     counts_reg [INTERFACES];

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rdata_reg;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;

    logic              cnt_we;
    logic [CW-1:0]     cnt_wdata;
    logic [CW-1:0]     cnt_cur;

    function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p, input logic [4:0] s);
        return AW'(int'(p) * SERVERS + int'(s));
    endfunction

    assign cnt_cur = counts_reg[port_reg];
    assign rsp = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        port_next = port_reg;
        addr_next = addr_reg;
        pos_next = pos_reg;
        idx_next = idx_reg;
        res_next = res_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall = 1'b1;
        mem_re = 1'b0;
        mem_raddr = '0;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = addr_reg;
        cnt_we = 1'b0;
        cnt_wdata = cnt_cur;

        unique case (state_reg)
            ppsst_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    op_next = req.operation;
                    addr_next = req.address;
                    pos_next = req.position;
                    if ({28'd0, req.port_index} < 32'(INTERFACES))
                    begin
                        port_next = PW'(req.port_index);
                        state_next = ppsst_pkg::ST_DECODE;
                    end
                    else
                    begin
                        port_next = '0;
                        res_next = '0;
                        state_next = ppsst_pkg::ST_DONE;
                    end
                end
            end
            ppsst_pkg::ST_DECODE:
            begin
                idx_next = '0;
                res_next.ok = 1'b0;
                res_next.read_address = '0;
                res_next.entry_count = 5'(cnt_cur);
                unique case (op_reg)
                    ppsst_pkg::OP_READ:
                    begin
                        if (5'(pos_reg) < 5'(cnt_cur))
                        begin
                            mem_re = 1'b1;
                            mem_raddr = slot_addr(port_reg, 5'(pos_reg));
                            state_next = ppsst_pkg::ST_READ_WAIT;
                        end
                        else
                        begin
                            state_next = ppsst_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ppsst_pkg::ST_SCAN_RD;
                    end
                endcase
            end
            ppsst_pkg::ST_SCAN_RD:
            begin
                if (idx_reg == cnt_cur)
                begin
                    if (op_reg == ppsst_pkg::OP_ADD && addr_reg != '0 && cnt_cur != FULL)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = slot_addr(port_reg, 5'(cnt_cur));
                        cnt_we = 1'b1;
                        cnt_wdata = cnt_cur + CW'(1);
                        res_next.ok = 1'b1;
                        res_next.entry_count = 5'(cnt_cur) + 5'd1;
                    end
                    state_next = ppsst_pkg::ST_DONE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = slot_addr(port_reg, 5'(idx_reg));
                    state_next = ppsst_pkg::ST_SCAN_CMP;
                end
            end
            ppsst_pkg::ST_SCAN_CMP:
            begin
                if (rdata_reg == addr_reg)
                begin
                    unique case (op_reg)
                        ppsst_pkg::OP_REMOVE:
                        begin
                            state_next = ppsst_pkg::ST_SHIFT_RD;
                        end
                        ppsst_pkg::OP_TEST:
                        begin
                            res_next.ok = 1'b1;
                            state_next = ppsst_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = ppsst_pkg::ST_DONE;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = ppsst_pkg::ST_SCAN_RD;
                end
            end
            ppsst_pkg::ST_SHIFT_RD:
            begin
                if (5'(idx_reg) + 5'd1 < 5'(cnt_cur))
                begin
                    mem_re = 1'b1;
                    mem_raddr = slot_addr(port_reg, 5'(idx_reg) + 5'd1);
                    state_next = ppsst_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    cnt_we = 1'b1;
                    cnt_wdata = cnt_cur - CW'(1);
                    res_next.ok = 1'b1;
                    res_next.entry_count = 5'(cnt_cur) - 5'd1;
                    state_next = ppsst_pkg::ST_DONE;
                end
            end
            ppsst_pkg::ST_SHIFT_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = slot_addr(port_reg, 5'(idx_reg));
                mem_wdata = rdata_reg;
                idx_next = idx_reg + CW'(1);
                state_next = ppsst_pkg::ST_SHIFT_RD;
            end
            ppsst_pkg::ST_READ_WAIT:
            begin
                res_next.ok = 1'b1;
                res_next.read_address = rdata_reg;
                state_next = ppsst_pkg::ST_DONE;
            end
            ppsst_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next = ppsst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppsst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppsst_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < INTERFACES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cnt_we)
            begin
                counts_reg[port_reg] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        port_reg <= port_next;
        addr_reg <= addr_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

[design/ppsst_checker.sv]
`include "assert_macros.svh"

module ppsst_checker #(
    parameter int SERVERS = ppsst_pkg::SERVERS_DEF
) (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input ppsst_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input ppsst_pkg::rsp_t rsp
);

    // A stalled result word stays in place until it is taken.
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp word changed while stalled")

    // The block works on one request at a time.
    `ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while busy")

    // Only a successful read returns a nonzero address.
    `ASSERT_IMPLY(a_read_addr_ok, rsp_valid && !rsp.ok, rsp.read_address == 32'd0, "address without ok")

    // A list never holds more than its capacity.
    `ASSERT_IMPLY(a_count_range, rsp_valid, 32'(rsp.entry_count) <= SERVERS, "entry count above capacity")

endmodule

bind per_port_server_set_table ppsst_checker #(.SERVERS(SERVERS)) u_ppsst_checker (.*);
